>>> hw/rtl/snu_pkg.sv
// ----------------------------------------------------------------------------
// snu_pkg
// Shared widths, constants and types for the surface normal unit.
// ----------------------------------------------------------------------------
package snu_pkg;

   localparam int CompW       = 12;   // Q2.10 input component
   localparam int ProdW       = 24;   // product of two components
   localparam int CrossW      = 25;   // cross product component
   localparam int SqW         = 48;   // squared length
   localparam int RootW       = 24;   // floor square root of SqW bits
   localparam int RemW        = 26;   // partial remainder width
   localparam int QuotW       = 15;   // quotient, up to UnitOne
   localparam int OutW        = 16;   // Q1.14 output component
   localparam int UnitOne     = 16384;
   localparam int QueueDepth  = 8;
   localparam int QueueAw     = 3;
   localparam int CountW      = 4;    // holds 0..QueueDepth
   localparam int FlightW     = 3;    // holds 0..FrontStages
   localparam int FrontStages = 4;
   localparam int SqrtStages  = 24;
   localparam int DivStages   = 15;
   localparam int Lanes       = 3;

   // classified item handed from the front part to the back part
   typedef struct packed {
      logic signed [CrossW-1:0] c_x;
      logic signed [CrossW-1:0] c_y;
      logic signed [CrossW-1:0] c_z;
      logic [SqW-1:0]           sq_len;
      logic                     degenerate;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

endpackage

>>> hw/rtl/snu_front.sv
// ----------------------------------------------------------------------------
// snu_front
// Cross product, squared length and degenerate test, four register stages.
// ----------------------------------------------------------------------------
module snu_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [6*snu_pkg::CompW-1:0]   in_data,
   input  logic [snu_pkg::SqW-1:0]       threshold,
   output snu_pkg::push_type             push,
   output logic [snu_pkg::FlightW-1:0]   in_flight
);
   import snu_pkg::*;

   logic signed [CompW-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
   logic [FrontStages-2:0]  valid_ff;
   logic signed [ProdW-1:0] prod_ff [6];
   logic signed [CrossW-1:0] c1_ff [Lanes];
   logic signed [CrossW-1:0] c2_ff [Lanes];
   logic [SqW-1:0]          sq_ff [Lanes];
   logic [2*CrossW-1:0]     sq_full [Lanes];
   logic [SqW-1:0]          sum_in;
   logic                    push_valid_ff;
   job_type                 job_ff;

   assign a_x = in_data[0*CompW +: CompW];
   assign a_y = in_data[1*CompW +: CompW];
   assign a_z = in_data[2*CompW +: CompW];
   assign b_x = in_data[3*CompW +: CompW];
   assign b_y = in_data[4*CompW +: CompW];
   assign b_z = in_data[5*CompW +: CompW];

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         push_valid_ff <= 1'b0;
      end else begin
         valid_ff      <= {valid_ff[FrontStages-3:0], in_valid};
         push_valid_ff <= valid_ff[FrontStages-2];
      end
   end

   // squares of the cross components
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         sq_full[i] = (2*CrossW)'(c1_ff[i] * c1_ff[i]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // products, differences, squares, sum and compare
   always_ff @(posedge clock) begin
      prod_ff[0] <= a_y * b_z;
      prod_ff[1] <= a_z * b_y;
      prod_ff[2] <= a_z * b_x;
      prod_ff[3] <= a_x * b_z;
      prod_ff[4] <= a_x * b_y;
      prod_ff[5] <= a_y * b_x;
      for (int i = 0; i < Lanes; i++) begin
         c1_ff[i] <= CrossW'(prod_ff[2*i]) - CrossW'(prod_ff[2*i+1]);
         c2_ff[i] <= c1_ff[i];
         sq_ff[i] <= sq_full[i][SqW-1:0];
      end
      job_ff.c_x        <= c2_ff[0];
      job_ff.c_y        <= c2_ff[1];
      job_ff.c_z        <= c2_ff[2];
      job_ff.sq_len     <= sum_in;
      job_ff.degenerate <= (sum_in <= threshold);
   end

   assign push.valid = push_valid_ff;
   assign push.job   = job_ff;
   assign in_flight  = FlightW'($countones({valid_ff, push_valid_ff}));

endmodule

>>> hw/rtl/snu_queue.sv
// ----------------------------------------------------------------------------
// snu_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module snu_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  snu_pkg::push_type             push,
   input  logic                          pop,
   output snu_pkg::push_type             head,
   output logic [snu_pkg::CountW-1:0]    count
);
   import snu_pkg::*;

   job_type              mem_ff [QueueDepth];
   logic [QueueAw-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push.valid && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push.valid && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)     rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

>>> hw/rtl/snu_back.sv
// ----------------------------------------------------------------------------
// snu_back
// Pipelined square root, three pipelined dividers and the output register.
// ----------------------------------------------------------------------------
module snu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  snu_pkg::push_type             head,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [3*snu_pkg::OutW-1:0]    out_data,
   output logic                          out_degenerate
);
   import snu_pkg::*;

   logic en;

   // square root stages
   logic                sq_v_ff    [SqrtStages];
   logic [RemW-1:0]     sq_rem_ff  [SqrtStages];
   logic [RootW-1:0]    sq_root_ff [SqrtStages];
   logic [SqW-1:0]      sq_rad_ff  [SqrtStages];
   job_type             sq_job_ff  [SqrtStages];
   logic                sq_v_src   [SqrtStages];
   logic [RemW-1:0]     sq_rem_src [SqrtStages];
   logic [RootW-1:0]    sq_root_src[SqrtStages];
   logic [SqW-1:0]      sq_rad_src [SqrtStages];
   job_type             sq_job_src [SqrtStages];
   logic [RemW-1:0]     sq_rem_in  [SqrtStages];
   logic [RootW-1:0]    sq_root_in [SqrtStages];

   // divider stages, one lane per component
   logic                dv_v_ff    [DivStages];
   logic [RootW-1:0]    dv_root_ff [DivStages];
   logic [RemW-1:0]     dv_rem_ff  [DivStages][Lanes];
   logic [QuotW-1:0]    dv_q_ff    [DivStages][Lanes];
   logic [Lanes-1:0]    dv_neg_ff  [DivStages];
   logic                dv_deg_ff  [DivStages];
   logic                dv_v_src   [DivStages];
   logic [RootW-1:0]    dv_root_src[DivStages];
   logic [RemW-1:0]     dv_rem_src [DivStages][Lanes];
   logic [QuotW-1:0]    dv_q_src   [DivStages][Lanes];
   logic [Lanes-1:0]    dv_neg_src [DivStages];
   logic                dv_deg_src [DivStages];
   logic [RemW-1:0]     dv_rem_in  [DivStages][Lanes];
   logic [QuotW-1:0]    dv_q_in    [DivStages][Lanes];

   logic signed [CrossW-1:0] fin_c  [Lanes];
   logic [RemW-1:0]          fin_mag[Lanes];
   logic [RemW-1:0]          shifted, trial;
   logic [QuotW-1:0]         q_clamp;
   logic signed [OutW-1:0]   n_val  [Lanes];

   logic                     out_valid_ff;
   logic [3*OutW-1:0]        out_data_ff;
   logic                     out_deg_ff;

   // the whole back part moves while the output register can take an item
   assign en  = !out_valid_ff || out_ready;
   assign pop = en && head.valid;

   // square root: one result bit per stage
   always_comb begin
      sq_v_src[0]    = head.valid;
      sq_rem_src[0]  = '0;
      sq_root_src[0] = '0;
      sq_rad_src[0]  = head.job.sq_len;
      sq_job_src[0]  = head.job;
      for (int k = 1; k < SqrtStages; k++) begin
         sq_v_src[k]    = sq_v_ff[k-1];
         sq_rem_src[k]  = sq_rem_ff[k-1];
         sq_root_src[k] = sq_root_ff[k-1];
         sq_rad_src[k]  = sq_rad_ff[k-1];
         sq_job_src[k]  = sq_job_ff[k-1];
      end
      for (int k = 0; k < SqrtStages; k++) begin
         shifted = {sq_rem_src[k][RemW-3:0], sq_rad_src[k][SqW-1 -: 2]};
         trial   = {sq_root_src[k], 2'b01};
         if (shifted >= trial) begin
            sq_rem_in[k]  = shifted - trial;
            sq_root_in[k] = {sq_root_src[k][RootW-2:0], 1'b1};
         end else begin
            sq_rem_in[k]  = shifted;
            sq_root_in[k] = {sq_root_src[k][RootW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SqrtStages; k++) sq_v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < SqrtStages; k++) sq_v_ff[k] <= sq_v_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SqrtStages; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_rad_ff[k]  <= {sq_rad_src[k][SqW-3:0], 2'b00};
            sq_job_ff[k]  <= sq_job_src[k];
         end
      end
   end

   // divider: integer bit first, then one fraction bit per stage
   always_comb begin
      fin_c[0] = sq_job_ff[SqrtStages-1].c_x;
      fin_c[1] = sq_job_ff[SqrtStages-1].c_y;
      fin_c[2] = sq_job_ff[SqrtStages-1].c_z;
      for (int i = 0; i < Lanes; i++) begin
         fin_mag[i] = fin_c[i][CrossW-1] ? RemW'(-fin_c[i]) : RemW'(fin_c[i]);
      end
      dv_v_src[0]    = sq_v_ff[SqrtStages-1];
      dv_root_src[0] = sq_root_ff[SqrtStages-1];
      dv_deg_src[0]  = sq_job_ff[SqrtStages-1].degenerate;
      for (int i = 0; i < Lanes; i++) begin
         dv_rem_src[0][i] = fin_mag[i];
         dv_q_src[0][i]   = '0;
         dv_neg_src[0][i] = fin_c[i][CrossW-1];
      end
      for (int k = 1; k < DivStages; k++) begin
         dv_v_src[k]    = dv_v_ff[k-1];
         dv_root_src[k] = dv_root_ff[k-1];
         dv_deg_src[k]  = dv_deg_ff[k-1];
         dv_neg_src[k]  = dv_neg_ff[k-1];
         for (int i = 0; i < Lanes; i++) begin
            dv_rem_src[k][i] = {dv_rem_ff[k-1][i][RemW-2:0], 1'b0};
            dv_q_src[k][i]   = dv_q_ff[k-1][i];
         end
      end
      for (int k = 0; k < DivStages; k++) begin
         for (int i = 0; i < Lanes; i++) begin
            if (dv_rem_src[k][i] >= RemW'(dv_root_src[k])) begin
               dv_rem_in[k][i] = dv_rem_src[k][i] - RemW'(dv_root_src[k]);
               dv_q_in[k][i]   = {dv_q_src[k][i][QuotW-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = dv_rem_src[k][i];
               dv_q_in[k][i]   = {dv_q_src[k][i][QuotW-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DivStages; k++) dv_v_ff[k] <= 1'b0;
      end else if (en) begin
         for (int k = 0; k < DivStages; k++) dv_v_ff[k] <= dv_v_src[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DivStages; k++) begin
            dv_root_ff[k] <= dv_root_src[k];
            dv_deg_ff[k]  <= dv_deg_src[k];
            dv_neg_ff[k]  <= dv_neg_src[k];
            for (int i = 0; i < Lanes; i++) begin
               dv_rem_ff[k][i] <= dv_rem_in[k][i];
               dv_q_ff[k][i]   <= dv_q_in[k][i];
            end
         end
      end
   end

   // clamp, sign and zero for degenerate items
   always_comb begin
      for (int i = 0; i < Lanes; i++) begin
         q_clamp = (dv_q_ff[DivStages-1][i] > QuotW'(UnitOne)) ?
                   QuotW'(UnitOne) : dv_q_ff[DivStages-1][i];
         if (dv_deg_ff[DivStages-1]) begin
            n_val[i] = '0;
         end else if (dv_neg_ff[DivStages-1][i]) begin
            n_val[i] = -$signed({1'b0, q_clamp});
         end else begin
            n_val[i] = $signed({1'b0, q_clamp});
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_v_ff[DivStages-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_data_ff <= {n_val[2], n_val[1], n_val[0]};
         out_deg_ff  <= dv_deg_ff[DivStages-1];
      end
   end

   assign out_valid      = out_valid_ff;
   assign out_data       = out_data_ff;
   assign out_degenerate = out_deg_ff;

endmodule

>>> hw/rtl/surface_normal_unit.sv
// ----------------------------------------------------------------------------
// surface_normal_unit
// Unit normal in Q1.14 from the cross product of two Q2.10 vectors.
// ----------------------------------------------------------------------------
// Takes one vector pair per clock and gives one result per clock while the
// result side keeps up. The front part (four stages: products, cross
// components, squares, sum and threshold compare) writes into an eight-entry
// queue, which adds one register; the back part reads it and runs a
// 24-stage square root, three 15-stage dividers in parallel and an output
// register, through which an item passes after any queue wait. The input
// side stays ready while the queue plus the items in the front part leave a
// free entry, so a stall on the result side reaches the input only after the
// queue has filled.
module surface_normal_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [47:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // a_x, a_y, a_z, b_x, b_y, b_z
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // n_x, n_y, n_z
   output logic        rsp_tuser    // degenerate
);
   import snu_pkg::*;

   logic [SqW-1:0]     threshold_ff;
   push_type           push, head;
   logic               pop;
   logic [CountW-1:0]  count;
   logic [FlightW-1:0] in_flight;
   logic               accept;

   // degenerate threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
      end else if (csr_wr_en) begin
         threshold_ff <= csr_wr_data;
      end
   end

   // keep one queue entry for every item the front part holds
   assign req_tready = ((CountW+1)'(count) + (CountW+1)'(in_flight))
                       < (CountW+1)'(QueueDepth);
   assign accept     = req_tvalid && req_tready;

   snu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_data   (req_tdata),
      .threshold (threshold_ff),
      .push      (push),
      .in_flight (in_flight)
   );

   snu_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .count (count)
   );

   snu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_data       (rsp_tdata),
      .out_degenerate (rsp_tuser)
   );

endmodule

>>> hw/rtl/snu_checker.sv
// ----------------------------------------------------------------------------
// snu_checker
// Port-level checks on the result stream of the surface normal unit.
// ----------------------------------------------------------------------------
module snu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // degenerate items carry the zero vector
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 48'd0)
      else $error("degenerate item with non-zero normal");

   // a real normal is never the zero vector
   a_norm_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != 48'd0)
      else $error("normal is zero without degenerate flag");

   // components stay within plus or minus one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(rsp_tdata[15:0]) <= 16'sd16384
         && $signed(rsp_tdata[15:0]) >= -16'sd16384
         && $signed(rsp_tdata[31:16]) <= 16'sd16384
         && $signed(rsp_tdata[31:16]) >= -16'sd16384
         && $signed(rsp_tdata[47:32]) <= 16'sd16384
         && $signed(rsp_tdata[47:32]) >= -16'sd16384)
      else $error("normal component out of range");

endmodule

bind surface_normal_unit snu_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

>>> verif/surface_normal_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surface_normal_unit_tb
// Self-checking bench for the surface normal unit.
// ----------------------------------------------------------------------------
// Drives vector pairs through a directed table and then random phases with
// varying idle and stall rates, predicts every normal in integer arithmetic
// and compares each result item in order with the predicted queue.
// ----------------------------------------------------------------------------
module surface_normal_unit_tb;
   import snu_pkg::*;

   typedef struct packed {
      logic signed [OutW-1:0] n_x;
      logic signed [OutW-1:0] n_y;
      logic signed [OutW-1:0] n_z;
      logic                   degen;
   } normal_type;

   typedef struct {
      logic signed [CompW-1:0] v [6];
      logic                    known;
      normal_type              want;
   } vec_row_type;

   localparam logic [47:0] MaxThresh = 48'hBFFF_FFFF_FFFF;
   localparam longint CycleLimit = 4000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [47:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   logic [47:0] thresh_model = '0;
   normal_type  normal_q [$];
   int          errors = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   longint      cycles = 0;

   surface_normal_unit u_top (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // floor square root, bit by bit
   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [OutW-1:0] unit_comp(longint c, longint unsigned r);
      longint unsigned m, q;
      m = (c < 0) ? -c : c;
      q = (m << 14) / r;
      if (q > 64'(UnitOne)) q = 64'(UnitOne);
      return OutW'((c < 0) ? -q : q);
   endfunction

   function automatic normal_type predict_normal(logic signed [CompW-1:0] v [6]);
      longint ax, ay, az, bx, by, bz, cx, cy, cz;
      longint unsigned s, r;
      normal_type n;
      ax = v[0]; ay = v[1]; az = v[2]; bx = v[3]; by = v[4]; bz = v[5];
      cx = ay * bz - az * by;
      cy = az * bx - ax * bz;
      cz = ax * by - ay * bx;
      s = cx * cx + cy * cy + cz * cz;
      if (s <= thresh_model) begin
         n = '{0, 0, 0, 1'b1};
      end else begin
         r = root_floor(s);
         n = '{unit_comp(cx, r), unit_comp(cy, r), unit_comp(cz, r), 1'b0};
      end
      return n;
   endfunction

   // result side: random stall and in-order compare
   always @(posedge clock) begin
      normal_type got, exp_n;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser};
         if (normal_q.size() == 0) begin
            $display("%0t: unexpected item, actual %h %b", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            exp_n = normal_q.pop_front();
            if (got != exp_n) begin
               $display("%0t: mismatch expected %0d %0d %0d %b actual %0d %0d %0d %b",
                        $time, exp_n.n_x, exp_n.n_y, exp_n.n_z, exp_n.degen,
                        got.n_x, got.n_y, got.n_z, got.degen);
               errors++;
            end
         end
      end
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic send_vec(logic signed [CompW-1:0] v [6], logic known, normal_type want);
      normal_type n;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {v[5], v[4], v[3], v[2], v[1], v[0]};
      n = predict_normal(v);
      if (known && n != want) begin
         $display("%0t: table row disagrees, expected %0d %0d %0d %b actual %0d %0d %0d %b",
                  $time, want.n_x, want.n_y, want.n_z, want.degen,
                  n.n_x, n.n_y, n.n_z, n.degen);
         errors++;
      end
      normal_q.push_back(n);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      while (normal_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic set_thresh(logic [47:0] t);
      drain_all();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= t;
      thresh_model = t;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic signed [CompW-1:0] rand_comp(int mode);
      case (mode)
         0: return $urandom_range(1) ? -12'sd2048 : 12'sd2047;
         1: return $signed(12'($urandom_range(8))) - 12'sd4;
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic random_phase(int count, int idle, int stall);
      logic signed [CompW-1:0] v [6];
      int mode;
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) begin
         mode = $urandom_range(9);
         for (int k = 0; k < 6; k++)
            v[k] = rand_comp(mode == 0 ? 0 : (mode == 1 ? 1 : 2));
         // parallel pair now and then
         if (mode == 2) for (int k = 0; k < 3; k++) v[k+3] = v[k];
         send_vec(v, 1'b0, '{0, 0, 0, 1'b0});
      end
   endtask

   vec_row_type dir_rows [] = '{
      '{'{0, 0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 1'b1}},
      '{'{1024, 0, 0, 0, 1024, 0}, 1'b1, '{0, 0, 16384, 1'b0}},
      '{'{0, 1024, 0, 0, 0, 1024}, 1'b1, '{16384, 0, 0, 1'b0}},
      '{'{0, 0, 1024, 1024, 0, 0}, 1'b1, '{0, 16384, 0, 1'b0}},
      '{'{0, 1024, 0, 1024, 0, 0}, 1'b1, '{0, 0, -16384, 1'b0}},
      '{'{-2048, 0, 0, 0, -2048, 0}, 1'b1, '{0, 0, 16384, 1'b0}},
      '{'{2047, 0, 0, 0, 2047, 0}, 1'b1, '{0, 0, 16384, 1'b0}},
      '{'{-2048, 0, 0, 0, 2047, 0}, 1'b1, '{0, 0, -16384, 1'b0}},
      '{'{5, 5, 5, 5, 5, 5}, 1'b1, '{0, 0, 0, 1'b1}},
      '{'{-2048, -2048, -2048, 2047, 2047, 2047}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{-2048, 2047, -2048, 2047, -2048, 2047}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{-2048, 2047, 0, 0, -2048, 2047}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{1, 0, 0, 0, 1, 0}, 1'b1, '{0, 0, 16384, 1'b0}},
      '{'{1, 1, 0, 0, 0, 1}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{-1, -1, -1, 1, -1, 1}, 1'b0, '{0, 0, 0, 1'b0}},
      '{'{1365, -7, 300, -2, 911, -1500}, 1'b0, '{0, 0, 0, 1'b0}}
   };

   initial begin
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // directed table, threshold at reset value
      foreach (dir_rows[i]) send_vec(dir_rows[i].v, dir_rows[i].known, dir_rows[i].want);

      // everything below the largest square is flagged
      set_thresh(MaxThresh);
      send_vec(dir_rows[9].v, 1'b1, '{0, 0, 0, 1'b1});
      send_vec(dir_rows[1].v, 1'b1, '{0, 0, 0, 1'b1});
      set_thresh(48'hC000_0000_0000);
      send_vec(dir_rows[10].v, 1'b1, '{0, 0, 0, 1'b1});
      // unit cross product squared is 1, threshold 1 flags it
      set_thresh(48'd1);
      send_vec(dir_rows[12].v, 1'b1, '{0, 0, 0, 1'b1});
      set_thresh(48'd0);

      random_phase(350, 0, 0);
      drain_all();
      random_phase(350, 70, 0);
      set_thresh(48'd20000000);
      random_phase(350, 0, 70);
      set_thresh(48'($urandom_range(32'h7FFF_FFFF)) << 16);
      random_phase(100, 32, 32);
      set_thresh(48'd0);
      random_phase(250, 32, 32);

      stall_pct = 0;
      drain_all();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
